// File: hw/rtl/fpo_pkg.sv
// Shared types and constants of the polygon inset offset unit.
// Used by every module of the block but fpo_div; depends on nothing.
package fpo_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned THICK_W = 31;
  localparam int unsigned QUEUE_DEPTH = 4;

  // One unit vector component of value 1.0 (Q2.30).
  localparam logic [31:0] UNIT_ONE = 32'h4000_0000;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  // One corner to evaluate: previous, current and next vertex (x low, y high).
  typedef struct packed {
    logic [63:0]      pv;
    logic [63:0]      cv;
    logic [63:0]      nv;
    logic [IDX_W-1:0] idx;
    logic             fin;
    logic             short_poly;
    logic             force_sat;
  } job_t;

endpackage

// File: hw/rtl/fpo_if.sv
// Handshake interfaces for the vertex input and the inset result output.
// Depends on nothing.
interface fpo_pt_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               end_of_polygon;
  modport source(output valid, point_x, point_y, end_of_polygon, input ready);
  modport sink(input valid, point_x, point_y, end_of_polygon, output ready);
endinterface

interface fpo_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] inner_x;
  logic signed [31:0] inner_y;
  logic [15:0]        vertex_index;
  logic               final_result;
  logic [1:0]         status;
  modport source(output valid, inner_x, inner_y, vertex_index, final_result, status,
                 input ready);
  modport sink(input valid, inner_x, inner_y, vertex_index, final_result, status,
               output ready);
endinterface

// File: hw/rtl/polygon_inset_offset_unit.sv
// Polygon inset offset unit, top level: thickness register, front end, queue, engine.
// Depends on fpo_pkg, fpo_if, fpo_front, fpo_fifo and fpo_back.
//
// Usage: vertex words enter on pt_i (valid/ready), one vertex each, with
// end_of_polygon set on the last vertex of a closed polygon. Inset words
// leave on res_o (valid/ready): vertex 1 comes when vertex 2 is taken, and
// so on; the closing vertex yields vertex n-1 and then vertex 0 with
// final_result set. Polygons with fewer than three vertices yield a single
// word with status 1. The thickness register is written by thickness_we_i
// and thickness_i; the user must write it only while the unit is idle, as
// the block itself does not enforce this. The front end takes a word and
// then queues the corner jobs it yields (up to three); it takes no new word
// until all are queued. The engine works one corner at a time with the
// bit-serial square root (32 steps per edge) and the shared 64-step
// divider, used six times per corner; a degenerate corner with a
// zero-length edge skips both. Reset clears the polygon state, the queue
// and the output register, and sets the thickness to zero. When the
// receiver stalls, the output register holds its word, the engine waits
// with its next word, the queue fills and pt_i.ready then drops.
module polygon_inset_offset_unit import fpo_pkg::*; #(
  parameter int INDEX_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        thickness_we_i,
  input  logic [30:0] thickness_i,
  fpo_pt_if.sink      pt_i,
  fpo_res_if.source   res_o
);

  logic [30:0] thickness_q;
  logic        full, empty, push, pop;
  job_t        job, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thickness_q <= '0;
    else if (thickness_we_i) thickness_q <= thickness_i;
  end

  fpo_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pt_i   (pt_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job)
  );

  fpo_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  fpo_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .thickness_i (thickness_q),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule

// File: hw/rtl/fpo_front.sv
// Front end: accepts vertex words, tracks the polygon window and queues corner jobs.
// Depends on fpo_pkg and fpo_if.
module fpo_front import fpo_pkg::*; #(
  parameter int INDEX_BITS = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  fpo_pt_if.sink pt_i,
  input  logic   full_i,
  output logic   push_o,
  output job_t   job_o
);

  localparam int CW = INDEX_BITS + 1;
  localparam logic [CW-1:0] COUNT_MAX = '1;
  localparam logic [CW-1:0] INDEX_LIMIT = CW'(1) << INDEX_BITS;

  logic [63:0]   first_q, second_q, prev_q, cur_q;
  logic [CW-1:0] cnt_q, n_q;
  logic [2:0]    pend_q, pend_d;
  job_t          job_a_q;

  logic          accept;
  logic [63:0]   v;
  logic [CW-1:0] n_new;

  function automatic logic [IDX_W:0] map_idx(input logic [CW-1:0] i);
    logic [31:0] w;
    begin
      if (i >= INDEX_LIMIT) begin
        w = 32'(INDEX_LIMIT - CW'(1));
        map_idx = {1'b1, w[IDX_W-1:0]};
      end else begin
        w = 32'(i);
        map_idx = {1'b0, w[IDX_W-1:0]};
      end
    end
  endfunction

  assign pt_i.ready = (pend_q == 3'b000);
  assign accept = pt_i.valid && pt_i.ready;
  assign v = {pt_i.point_y, pt_i.point_x};
  assign n_new = (cnt_q < COUNT_MAX) ? cnt_q + CW'(1) : cnt_q;

  // Job selection, oldest pending first.
  always_comb begin
    logic [IDX_W:0] m;
    job_o = job_a_q;
    m = map_idx(n_q - CW'(1));
    if (!pend_q[0] && pend_q[1]) begin
      job_o.pv = prev_q;
      job_o.cv = cur_q;
      job_o.nv = first_q;
      job_o.fin = (n_q < CW'(3));
      job_o.short_poly = (n_q < CW'(3));
      job_o.idx = (n_q < CW'(3)) ? '0 : m[IDX_W-1:0];
      job_o.force_sat = (n_q < CW'(3)) ? 1'b0 : m[IDX_W];
    end else if (!pend_q[0] && !pend_q[1]) begin
      job_o.pv = cur_q;
      job_o.cv = first_q;
      job_o.nv = second_q;
      job_o.fin = 1'b1;
      job_o.short_poly = 1'b0;
      job_o.idx = '0;
      job_o.force_sat = (n_q > INDEX_LIMIT);
    end
    push_o = (pend_q != 3'b000) && !full_i;
    pend_d = pend_q;
    if (push_o) begin
      if (pend_q[0]) pend_d[0] = 1'b0;
      else if (pend_q[1]) pend_d[1] = 1'b0;
      else pend_d[2] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
      prev_q   <= '0;
      cur_q    <= '0;
      cnt_q    <= '0;
      n_q      <= '0;
      pend_q   <= '0;
    end else if (accept) begin
      if (cnt_q == CW'(0)) first_q <= v;
      if (cnt_q == CW'(1)) second_q <= v;
      prev_q <= cur_q;
      cur_q  <= v;
      n_q    <= n_new;
      cnt_q  <= pt_i.end_of_polygon ? '0 : n_new;
      pend_q <= {pt_i.end_of_polygon && (n_new >= CW'(3)), pt_i.end_of_polygon,
                 cnt_q >= CW'(2)};
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [IDX_W:0] m;
    m = map_idx(cnt_q - CW'(1));
    if (accept) begin
      job_a_q.pv <= prev_q;
      job_a_q.cv <= cur_q;
      job_a_q.nv <= v;
      job_a_q.idx <= m[IDX_W-1:0];
      job_a_q.force_sat <= m[IDX_W];
      job_a_q.fin <= 1'b0;
      job_a_q.short_poly <= 1'b0;
    end
  end

endmodule

// File: hw/rtl/fpo_fifo.sv
// Short job queue between the front end and the corner engine.
// Depends on fpo_pkg.
module fpo_fifo import fpo_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t head_o,
  output logic full_o,
  output logic empty_o
);

  localparam int AW = $clog2(DEPTH);

  job_t          mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign head_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      if (pop_i) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + (AW+1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (AW+1)'(1);
    end
  end

endmodule

// File: hw/rtl/fpo_div.sv
// Bit-serial unsigned divider, one quotient bit per cycle, 64 quotient bits.
// Depends on nothing.
module fpo_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic [32:0] rem_q;
  logic [63:0] quo_q;
  logic [31:0] den_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] sh;
  logic        take;

  assign sh = {rem_q[31:0], quo_q[63]};
  assign take = (sh >= {1'b0, den_q});
  assign done_o = done_q;
  assign quo_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd63);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= take ? sh - {1'b0, den_q} : sh;
      quo_q <= {quo_q[62:0], take};
    end
  end

endmodule

// File: hw/rtl/fpo_back.sv
// Corner engine: unit vectors, cross product, miter offset, clamp and output register.
// Depends on fpo_pkg, fpo_if and fpo_div.
module fpo_back import fpo_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [30:0]  thickness_i,
  input  logic         empty_i,
  input  job_t         head_i,
  output logic         pop_o,
  fpo_res_if.source    res_o
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_LOAD = 5'd1;
  localparam logic [4:0] S_NORM = 5'd2;
  localparam logic [4:0] S_SQX  = 5'd3;
  localparam logic [4:0] S_SQY  = 5'd4;
  localparam logic [4:0] S_SQS  = 5'd5;
  localparam logic [4:0] S_SQRT = 5'd6;
  localparam logic [4:0] S_UDS  = 5'd7;
  localparam logic [4:0] S_UDW  = 5'd8;
  localparam logic [4:0] S_CR1  = 5'd9;
  localparam logic [4:0] S_CR2  = 5'd10;
  localparam logic [4:0] S_CR3  = 5'd11;
  localparam logic [4:0] S_NM   = 5'd12;
  localparam logic [4:0] S_ODS  = 5'd13;
  localparam logic [4:0] S_ODW  = 5'd14;
  localparam logic [4:0] S_FIN  = 5'd15;
  localparam logic [4:0] S_EMIT = 5'd16;

  logic [4:0]         state_q;
  job_t               job_q;
  logic               side_q, axis_q;
  logic [32:0]        mx_q, my_q;
  logic               sx_q, sy_q;
  logic signed [63:0] mul_q, acc_q;
  logic [63:0]        sqv_q, sqr_q, sqb_q;
  logic [30:0]        len_q;
  logic signed [31:0] px_q, py_q, nx_q, ny_q;
  logic [31:0]        c30_q;
  logic               csg_q, coll_q, nsg_q;
  logic signed [63:0] ox_q, oy_q;
  logic signed [31:0] rx_q, ry_q;
  logic [1:0]         st_q;
  logic               ov_q;
  logic signed [31:0] ox_out_q, oy_out_q;
  logic [15:0]        oidx_q;
  logic               ofin_q;
  logic [1:0]         ost_q;

  logic signed [31:0] cx, cy;
  logic signed [32:0] dx, dy, ex, ey;
  logic [32:0]        m;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic [63:0]        sq_t;
  logic               div_start, div_done;
  logic [63:0]        div_num, div_quo;
  logic [31:0]        div_den, uq;
  logic signed [63:0] diff;
  logic [63:0]        diff_mag, mul_mag;
  logic signed [32:0] numer;
  logic signed [65:0] sum_x, sum_y;
  logic               emit_go;

  function automatic logic signed [32:0] sx33(input logic signed [31:0] a);
    sx33 = {a[31], a};
  endfunction

  function automatic logic [32:0] abs33(input logic signed [32:0] a);
    abs33 = a[32] ? 33'(-a) : 33'(a);
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] s,
                                                 output logic sat);
    begin
      sat = (s[65:31] != {35{s[65]}});
      if (!sat) clamp32 = s[31:0];
      else clamp32 = s[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  endfunction

  assign cx = job_q.cv[31:0];
  assign cy = job_q.cv[63:32];
  assign dx = sx33(job_q.pv[31:0]) - sx33(cx);
  assign dy = sx33(job_q.pv[63:32]) - sx33(cy);
  assign ex = sx33(job_q.nv[31:0]) - sx33(cx);
  assign ey = sx33(job_q.nv[63:32]) - sx33(cy);
  assign m  = (mx_q > my_q) ? mx_q : my_q;
  assign sq_t = sqr_q + sqb_q;
  assign diff = acc_q - mul_q;
  assign diff_mag = diff[63] ? 64'(-diff) : 64'(diff);
  assign mul_mag = mul_q[63] ? 64'(-mul_q) : 64'(mul_q);
  assign uq = div_quo[31:0];

  always_comb begin
    if (!axis_q) numer = coll_q ? -sx33(ny_q) : sx33(px_q) + sx33(nx_q);
    else numer = coll_q ? sx33(nx_q) : sx33(py_q) + sx33(ny_q);
  end

  // Shared multiplier; its product is registered in mul_q every cycle.
  always_comb begin
    mul_a = $signed({3'b000, mx_q[29:0]});
    mul_b = $signed({3'b000, mx_q[29:0]});
    case (state_q)
      S_SQY: begin
        mul_a = $signed({3'b000, my_q[29:0]});
        mul_b = $signed({3'b000, my_q[29:0]});
      end
      S_CR1: begin
        mul_a = sx33(nx_q);
        mul_b = sx33(py_q);
      end
      S_CR2: begin
        mul_a = sx33(ny_q);
        mul_b = sx33(px_q);
      end
      S_NM: begin
        mul_a = $signed({2'b00, thickness_i});
        mul_b = numer;
      end
      default: ;
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    div_start = (state_q == S_UDS) || (state_q == S_ODS);
    if (state_q == S_UDS) begin
      div_den = {1'b0, len_q};
      div_num = {4'b0, (axis_q ? my_q[29:0] : mx_q[29:0]), 30'b0} + 64'(len_q >> 1);
    end else begin
      div_den = coll_q ? UNIT_ONE : c30_q;
      div_num = mul_mag + 64'(div_den >> 1);
    end
  end

  fpo_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign pop_o = (state_q == S_IDLE) && !empty_i;
  assign emit_go = (state_q == S_EMIT) && (!ov_q || res_o.ready);
  assign sum_x = $signed({{34{cx[31]}}, cx}) + $signed({{2{ox_q[63]}}, ox_q});
  assign sum_y = $signed({{34{cy[31]}}, cy}) + $signed({{2{oy_q[63]}}, oy_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      if (emit_go) ov_q <= 1'b1;
      else if (res_o.ready) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: if (!empty_i) state_q <= S_LOAD;
        S_LOAD: begin
          if (job_q.short_poly) state_q <= S_EMIT;
          else if ((dx == 0 && dy == 0) || (ex == 0 && ey == 0)) state_q <= S_EMIT;
          else state_q <= S_NORM;
        end
        S_NORM: if (m[32:30] == 3'b000 && m[29]) state_q <= S_SQX;
        S_SQX:  state_q <= S_SQY;
        S_SQY:  state_q <= S_SQS;
        S_SQS:  state_q <= S_SQRT;
        S_SQRT: if (sqb_q == '0) state_q <= S_UDS;
        S_UDS:  state_q <= S_UDW;
        S_UDW: begin
          if (div_done) begin
            if (!axis_q) state_q <= S_UDS;
            else if (!side_q) state_q <= S_NORM;
            else state_q <= S_CR1;
          end
        end
        S_CR1:  state_q <= S_CR2;
        S_CR2:  state_q <= S_CR3;
        S_CR3:  state_q <= S_NM;
        S_NM:   state_q <= S_ODS;
        S_ODS:  state_q <= S_ODW;
        S_ODW: begin
          if (div_done) state_q <= axis_q ? S_FIN : S_NM;
        end
        S_FIN:  state_q <= S_EMIT;
        S_EMIT: if (emit_go) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    logic sat_x, sat_y;
    logic signed [31:0] cl_x, cl_y;
    mul_q <= prod[63:0];
    cl_x = clamp32(sum_x, sat_x);
    cl_y = clamp32(sum_y, sat_y);
    case (state_q)
      S_IDLE: begin
        job_q <= head_i;
        side_q <= 1'b0;
        axis_q <= 1'b0;
      end
      S_LOAD: begin
        if (job_q.short_poly) begin
          rx_q <= '0;
          ry_q <= '0;
          st_q <= ST_SHORT;
        end else begin
          rx_q <= cx;
          ry_q <= cy;
          st_q <= ST_ZERO;
        end
        mx_q <= abs33(dx);
        my_q <= abs33(dy);
        sx_q <= dx[32];
        sy_q <= dy[32];
      end
      S_NORM: begin
        if (m[32:30] != 3'b000) begin
          mx_q <= mx_q >> 1;
          my_q <= my_q >> 1;
        end else if (!m[29]) begin
          mx_q <= mx_q << 1;
          my_q <= my_q << 1;
        end
      end
      S_SQY: acc_q <= mul_q;
      S_SQS: begin
        sqv_q <= 64'(acc_q + mul_q);
        sqr_q <= '0;
        sqb_q <= 64'd1 << 62;
      end
      S_SQRT: begin
        if (sqb_q != '0) begin
          if (sqv_q >= sq_t) begin
            sqv_q <= sqv_q - sq_t;
            sqr_q <= (sqr_q >> 1) + sqb_q;
          end else begin
            sqr_q <= sqr_q >> 1;
          end
          sqb_q <= sqb_q >> 2;
        end else begin
          len_q <= sqr_q[30:0];
        end
      end
      S_UDW: begin
        if (div_done) begin
          if (!axis_q) begin
            if (!side_q) px_q <= sx_q ? -$signed(uq) : $signed(uq);
            else nx_q <= sx_q ? -$signed(uq) : $signed(uq);
            axis_q <= 1'b1;
          end else begin
            if (!side_q) py_q <= sy_q ? -$signed(uq) : $signed(uq);
            else ny_q <= sy_q ? -$signed(uq) : $signed(uq);
            axis_q <= 1'b0;
            side_q <= 1'b1;
            mx_q <= abs33(ex);
            my_q <= abs33(ey);
            sx_q <= ex[32];
            sy_q <= ey[32];
          end
        end
      end
      S_CR2: acc_q <= mul_q;
      S_CR3: begin
        // Cross product truncated toward zero to Q.30.
        c30_q  <= diff_mag[61:30];
        csg_q  <= diff[63];
        coll_q <= (diff_mag[63:30] == '0);
        axis_q <= 1'b0;
      end
      S_ODS: nsg_q <= mul_q[63] ^ (csg_q && !coll_q);
      S_ODW: begin
        if (div_done) begin
          if (!axis_q) ox_q <= nsg_q ? -$signed(div_quo) : $signed(div_quo);
          else oy_q <= nsg_q ? -$signed(div_quo) : $signed(div_quo);
          axis_q <= 1'b1;
        end
      end
      S_FIN: begin
        rx_q <= cl_x;
        ry_q <= cl_y;
        st_q <= (sat_x || sat_y) ? ST_SAT : ST_OK;
      end
      default: ;
    endcase
    if (emit_go) begin
      ox_out_q <= rx_q;
      oy_out_q <= ry_q;
      oidx_q   <= job_q.idx;
      ofin_q   <= job_q.fin;
      ost_q    <= job_q.force_sat ? ST_SAT : st_q;
    end
  end

  assign res_o.valid        = ov_q;
  assign res_o.inner_x      = ox_out_q;
  assign res_o.inner_y      = oy_out_q;
  assign res_o.vertex_index = oidx_q;
  assign res_o.final_result = ofin_q;
  assign res_o.status       = ost_q;

endmodule

// File: hw/rtl/fpo_checker.sv
// Port-level checks on the result channel of the polygon inset offset unit.
// Depends on fpo_pkg and polygon_inset_offset_unit, to which it is bound.
module fpo_checker import fpo_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] res_x,
  input logic [31:0] res_y,
  input logic [15:0] res_idx,
  input logic        res_fin,
  input logic [1:0]  res_st
);

  // A short polygon reports the origin, index zero, and closes the polygon.
  a_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_st == ST_SHORT |-> res_fin && res_x == 32'd0 && res_y == 32'd0
                                        && res_idx == 16'd0)
    else $error("short polygon word malformed");

  // The closing word always belongs to vertex zero.
  a_final_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_fin |-> res_idx == 16'd0)
    else $error("final word not for vertex zero");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_x) && $stable(res_idx))
    else $error("stalled result word changed");

  // Reset clears the valid flag of the output register.
  a_reset: assert property (@(posedge clk_i) !rst_ni |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind polygon_inset_offset_unit fpo_checker u_fpo_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .res_valid (res_o.valid),
  .res_ready (res_o.ready),
  .res_x     (res_o.inner_x),
  .res_y     (res_o.inner_y),
  .res_idx   (res_o.vertex_index),
  .res_fin   (res_o.final_result),
  .res_st    (res_o.status)
);
